FILE: rtl/lrs_pkg.sv
// Shared types, constants and the CRC-32 byte step of the log record scanner.
package lrs_pkg;

  localparam int OFFSET_BITS = 48;
  localparam int RECORDS_W = 40;
  localparam int SEQNO_W = 64;
  localparam int GOOD_W = 48;
  localparam int LIMIT_W = 31;
  localparam int COUNT_W = 31;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1 << 30);
  localparam logic [LIMIT_W-1:0] MIN_PAYLOAD = LIMIT_W'(1 + 8 + 4 + 4);
  localparam logic [7:0] HDR_VERSION = 8'd1;
  localparam logic [7:0] TYPE_PUT = 8'd1;
  localparam logic [7:0] TYPE_DELETE = 8'd2;
  localparam logic [7:0] MAGIC [4] = '{8'h4C, 8'h53, 8'h4D, 8'h57};

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC     = 3'd3,
    PH_DEAD    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [RECORDS_W-1:0] records;
    logic [SEQNO_W-1:0]   seqno_peak;
    logic [GOOD_W-1:0]    good_offset;
    logic                 clean;
  } result_t;

  // One byte of the reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/lrs_parser.sv
// Segment parser: header check, record framing, CRC and per-segment totals.
module lrs_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           operation,
  input  logic [7:0]                     data_byte,
  input  logic                           cfg_we,
  input  logic [lrs_pkg::LIMIT_W-1:0]    cfg_data,
  output lrs_pkg::result_t               result
);
  import lrs_pkg::*;

  logic [LIMIT_W-1:0]     payload_limit;
  phase_t                 phase, phase_next;
  logic [COUNT_W-1:0]     section_count, section_count_next;
  logic [LIMIT_W-1:0]     payload_length, payload_length_next;
  logic [31:0]            running_crc, running_crc_next;
  logic [31:0]            stored_crc, stored_crc_next;
  logic [7:0]             record_type, record_type_next;
  logic [63:0]            record_seqno, record_seqno_next;
  logic [31:0]            key_length, key_length_next;
  logic [31:0]            value_length, value_length_next;
  logic [RECORDS_W-1:0]   record_total, record_total_next;
  logic [SEQNO_W-1:0]     seqno_max, seqno_max_next;
  logic [OFFSET_BITS-1:0] valid_offset, valid_offset_next;
  logic                   clean_flag, clean_flag_next;

  logic                   is_end;
  logic                   hdr_bad;
  logic                   hdr_last;
  logic                   len_last;
  logic [LIMIT_W-1:0]     len_full;
  logic                   len_bad;
  logic [COUNT_W-1:0]     count_inc;
  logic                   pay_done;
  logic [31:0]            crc_calc;
  logic [31:0]            crc_full;
  logic                   crc_last;
  logic                   rec_bad;
  logic [33:0]            len_sum;
  logic [OFFSET_BITS:0]   off_sum;
  logic [4:0]             fidx;
  logic [2:0]             seq_sel;
  logic [1:0]             word_sel;

  assign is_end    = (operation == OP_END);
  assign count_inc = section_count + COUNT_W'(1);

  assign hdr_bad = ((section_count < COUNT_W'(4)) && (data_byte != MAGIC[section_count[1:0]])) ||
                   ((section_count == COUNT_W'(4)) && (data_byte != HDR_VERSION));
  assign hdr_last = (section_count == COUNT_W'(7));

  assign len_last = (section_count == COUNT_W'(3));
  assign len_full = {data_byte[6:0], payload_length[23:0]};
  assign len_bad  = data_byte[7] || (len_full < MIN_PAYLOAD) || (len_full > payload_limit);

  assign pay_done = (count_inc >= payload_length);
  assign crc_calc = crc_byte(running_crc, data_byte);
  assign fidx     = section_count[4:0];

  assign crc_last = (section_count == COUNT_W'(3));
  assign crc_full = {data_byte, stored_crc[23:0]};
  assign len_sum  = 34'(MIN_PAYLOAD) + 34'(key_length) + 34'(value_length);
  assign rec_bad  = ((running_crc ^ CRC_ONES) != crc_full) ||
                    ((record_type != TYPE_PUT) && (record_type != TYPE_DELETE)) ||
                    (len_sum != 34'(payload_length)) ||
                    ((record_type == TYPE_DELETE) && (value_length != 32'd0));

  // Offset just past this record, saturating at the top of the offset range.
  assign off_sum = (OFFSET_BITS+1)'(valid_offset) + (OFFSET_BITS+1)'(payload_length) +
                   (OFFSET_BITS+1)'(8);

  // Phase sequencing.
  always_comb begin
    phase_next = phase;
    if (is_end) begin
      phase_next = PH_HEADER;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_bad) phase_next = PH_DEAD;
          else if (hdr_last) phase_next = PH_LEN;
        end
        PH_LEN: begin
          if (len_last) phase_next = len_bad ? PH_DEAD : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (pay_done) phase_next = PH_CRC;
        end
        PH_CRC: begin
          if (crc_last) phase_next = rec_bad ? PH_DEAD : PH_LEN;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Field capture and segment totals.
  always_comb begin
    section_count_next  = section_count;
    payload_length_next = payload_length;
    running_crc_next    = running_crc;
    stored_crc_next     = stored_crc;
    record_type_next    = record_type;
    record_seqno_next   = record_seqno;
    key_length_next     = key_length;
    value_length_next   = value_length;
    record_total_next   = record_total;
    seqno_max_next      = seqno_max;
    valid_offset_next   = valid_offset;
    clean_flag_next     = clean_flag;
    seq_sel             = 3'(fidx - 5'd1);
    word_sel            = 2'd0;
    if (is_end) begin
      section_count_next  = '0;
      payload_length_next = '0;
      running_crc_next    = CRC_ONES;
      stored_crc_next     = '0;
      record_type_next    = '0;
      record_seqno_next   = '0;
      key_length_next     = '0;
      value_length_next   = '0;
      record_total_next   = '0;
      seqno_max_next      = '0;
      valid_offset_next   = '0;
      clean_flag_next     = 1'b1;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (hdr_bad) begin
            valid_offset_next = '0;
            clean_flag_next   = 1'b0;
          end else if (hdr_last) begin
            valid_offset_next  = OFFSET_BITS'(8);
            section_count_next = '0;
          end else begin
            section_count_next = count_inc;
          end
        end
        PH_LEN: begin
          if (len_last) begin
            payload_length_next = len_full;
            if (len_bad) clean_flag_next = 1'b0;
            else section_count_next = '0;
          end else begin
            payload_length_next[8*section_count[1:0] +: 8] = data_byte;
            section_count_next = count_inc;
          end
        end
        PH_PAYLOAD: begin
          running_crc_next = crc_calc;
          if (section_count < COUNT_W'(17)) begin
            if (fidx == 5'd0) begin
              record_type_next = data_byte;
            end else if (fidx <= 5'd8) begin
              record_seqno_next[8*seq_sel +: 8] = data_byte;
            end else if (fidx <= 5'd12) begin
              word_sel = 2'(fidx - 5'd9);
              key_length_next[8*word_sel +: 8] = data_byte;
            end else begin
              word_sel = 2'(fidx - 5'd13);
              value_length_next[8*word_sel +: 8] = data_byte;
            end
          end
          section_count_next = pay_done ? '0 : count_inc;
        end
        PH_CRC: begin
          stored_crc_next[8*section_count[1:0] +: 8] = data_byte;
          section_count_next = count_inc;
          if (crc_last) begin
            if (rec_bad) begin
              clean_flag_next = 1'b0;
            end else begin
              if (record_total != '1) record_total_next = record_total + RECORDS_W'(1);
              if (record_seqno > seqno_max) seqno_max_next = record_seqno;
              valid_offset_next = off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];
              section_count_next  = '0;
              payload_length_next = '0;
              running_crc_next    = CRC_ONES;
              stored_crc_next     = '0;
              record_type_next    = '0;
              record_seqno_next   = '0;
              key_length_next     = '0;
              value_length_next   = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      payload_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      section_count  <= '0;
      payload_length <= '0;
      running_crc    <= CRC_ONES;
      stored_crc     <= '0;
      record_type    <= '0;
      record_seqno   <= '0;
      key_length     <= '0;
      value_length   <= '0;
      record_total   <= '0;
      seqno_max      <= '0;
      valid_offset   <= '0;
      clean_flag     <= 1'b1;
    end else if (accept) begin
      phase          <= phase_next;
      section_count  <= section_count_next;
      payload_length <= payload_length_next;
      running_crc    <= running_crc_next;
      stored_crc     <= stored_crc_next;
      record_type    <= record_type_next;
      record_seqno   <= record_seqno_next;
      key_length     <= key_length_next;
      value_length   <= value_length_next;
      record_total   <= record_total_next;
      seqno_max      <= seqno_max_next;
      valid_offset   <= valid_offset_next;
      clean_flag     <= clean_flag_next;
    end
  end

  // Summary as seen by an end item arriving now.
  always_comb begin
    result.records     = record_total;
    result.seqno_peak  = seqno_max;
    result.good_offset = (phase == PH_HEADER) ? '0 : GOOD_W'(valid_offset);
    result.clean       = clean_flag &&
                         (phase != PH_HEADER) &&
                         !((phase == PH_LEN) && (section_count != '0)) &&
                         (phase != PH_PAYLOAD) && (phase != PH_CRC);
  end

endmodule

FILE: rtl/lrs_out_reg.sv
// Result register that holds the segment summary until the receiver takes it.
module lrs_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lrs_pkg::result_t  load_data,
  input  logic              out_stall,
  output logic              out_valid,
  output lrs_pkg::result_t  out_data
);
  import lrs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

FILE: rtl/log_record_scanner_core.sv
// Top level of the log record scanner: input handshake, parser and result register.
//
// The input channel carries one item per transfer: a data byte of the segment
// (operation = 0) or the end-of-segment marker (operation = 1). Data bytes are
// parsed at the edge they are transferred; one byte is taken every cycle, the
// CRC-32 step and field capture being done in that same cycle.
// An end item yields exactly one result on the output channel: record count,
// largest sequence number, good byte offset and the clean flag. The result is
// valid in the cycle after the end item's transfer, and the parser is back at
// the header phase for the next segment at the edge that loads the result.
// Throughput is one item per cycle, limited only by the single result register.
// While a result waits under out_stall, data bytes keep flowing; only a further
// end item is held off by in_stall until the waiting result is transferred.
// The max_payload register is written on the cfg channel, which is always
// ready; write it only while no segment is in flight.
// Synchronous reset clears the parser to the header phase, empties the result
// register and sets max_payload back to 2^30.
module log_record_scanner_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [7:0]                   data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lrs_pkg::RECORDS_W-1:0] records,
  output logic [lrs_pkg::SEQNO_W-1:0]  seqno_peak,
  output logic [lrs_pkg::GOOD_W-1:0]   good_offset,
  output logic                         clean,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lrs_pkg::LIMIT_W-1:0]  max_payload
);
  import lrs_pkg::*;

  logic    in_accept;
  logic    end_accept;
  result_t summary;
  result_t out_data;

  // An end item needs the result register; it may proceed when the register is
  // empty or is being emptied in this very cycle.
  assign in_stall   = out_valid && out_stall && (operation == OP_END);
  assign in_accept  = in_valid && !in_stall;
  assign end_accept = in_accept && (operation == OP_END);
  assign cfg_ready  = 1'b1;

  lrs_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .operation (operation),
    .data_byte (data_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (max_payload),
    .result    (summary)
  );

  lrs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (end_accept),
    .load_data (summary),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign records     = out_data.records;
  assign seqno_peak  = out_data.seqno_peak;
  assign good_offset = out_data.good_offset;
  assign clean       = out_data.clean;

endmodule
